### rtl/core/bhds_pkg.sv
// ----------------------------------------------------------------------------
// bhds_pkg: shared types and constants
// Widths, nucleotide codes, register indexes and the control bundle that the
// top level hands to each mask cell.
// ----------------------------------------------------------------------------
package bhds_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    localparam int MASK_W = 64;            // width of one partial match mask
    localparam int POS_W  = 6;             // text position / check bit index
    localparam int DIST_W = 7;             // distance and pattern_length width
    localparam int NUC_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [NUC_W-1:0] NUC_A = 3'd0;
    localparam logic [NUC_W-1:0] NUC_C = 3'd1;
    localparam logic [NUC_W-1:0] NUC_G = 3'd2;
    localparam logic [NUC_W-1:0] NUC_T = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_A         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_C         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_G         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_T         = 3'd4;

    typedef struct packed {
        logic              upd;      // item accepted: advance active levels
        logic              clr;      // start of a new text
        logic              chk_en;   // capture the check bit
        logic [DIST_W-1:0] m;        // effective pattern length
        logic [POS_W-1:0]  chk_idx;  // check bit for the item in the cells
    } cell_ctl_t;

endpackage

### rtl/core/bhds_if.sv
// ----------------------------------------------------------------------------
// bhds_if: stream and configuration channels
// Valid/ready channels for text items, result items and register writes.
// ----------------------------------------------------------------------------
interface bhds_text_if;
    import bhds_pkg::*;
    logic             valid;
    logic             ready;
    logic [NUC_W-1:0] nucleotide;
    logic             text_start;
    modport source (output valid, nucleotide, text_start, input ready);
    modport sink   (input valid, nucleotide, text_start, output ready);
endinterface

interface bhds_result_if;
    import bhds_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

interface bhds_cfg_if;
    import bhds_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bhds_cell.sv
// ----------------------------------------------------------------------------
// bhds_cell: one mismatch level
// Holds the mask of one substitution count, advances it from its own and
// the lower neighbor's old mask, and registers its check bit.
// ----------------------------------------------------------------------------
module bhds_cell #(
    parameter int LEVEL = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bhds_pkg::cell_ctl_t          ctl,
    input  logic [bhds_pkg::MASK_W-1:0]  base,
    input  logic [bhds_pkg::MASK_W-1:0]  prev_mask,
    output logic [bhds_pkg::MASK_W-1:0]  mask,
    output logic                         flag
);
    import bhds_pkg::*;

    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [MASK_W-1:0] old_m, old_p, upd_mask;
    logic              flag_reg, flag_next;
    logic              active;

    // levels above m stay frozen, apart from a clear at text start
    assign active = (DIST_W'(LEVEL) <= ctl.m);

    always_comb
    begin
        old_m = ctl.clr ? '0 : mask_reg;
        old_p = ctl.clr ? '0 : prev_mask;
        if (LEVEL == 0)
        begin
            upd_mask = ((old_m << 1) | MASK_W'(1)) & base;
        end
        else
        begin
            upd_mask = ((old_m << 1) & base) | (old_p << 1) | MASK_W'(1);
        end
        mask_next = mask_reg;
        if (ctl.upd && active)
        begin
            mask_next = upd_mask;
        end
        else if (ctl.clr)
        begin
            mask_next = '0;
        end
        flag_next = ctl.chk_en ? (mask_reg[ctl.chk_idx] & active) : flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    assign mask = mask_reg;
    assign flag = flag_reg;

endmodule

### rtl/core/bhds_min_level.sv
// ----------------------------------------------------------------------------
// bhds_min_level: lowest set check bit
// Two registered stages: first set bit within groups of eight, then the
// first group that has one. No bit set gives m.
// ----------------------------------------------------------------------------
module bhds_min_level #(
    parameter int NUM_LEVELS = bhds_pkg::MAX_PATTERN_DEF + 1
) (
    input  logic                          clk,
    input  logic                          en_grp,
    input  logic                          en_out,
    input  logic [NUM_LEVELS-1:0]         flags,
    input  logic [bhds_pkg::DIST_W-1:0]   m,
    output logic [bhds_pkg::DIST_W-1:0]   distance
);
    import bhds_pkg::*;

    localparam int GROUPS = (NUM_LEVELS + 7) / 8;

    logic [GROUPS*8-1:0] padded;
    logic [GROUPS-1:0]   found_next, found_reg;
    logic [2:0]          idx_next [GROUPS];
    logic [2:0]          idx_reg  [GROUPS];
    logic [DIST_W-1:0]   dist_next, dist_reg;

    assign padded = (GROUPS*8)'(flags);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            found_next[g] = |padded[g*8 +: 8];
            idx_next[g]   = 3'd0;
            for (int b = 7; b >= 0; b--)
            begin
                if (padded[g*8 + b])
                begin
                    idx_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        dist_next = m;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (found_reg[g])
            begin
                dist_next = DIST_W'(g * 8) + DIST_W'(idx_reg[g]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_grp)
        begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
        if (en_out)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

endmodule

### rtl/core/bitap_hamming_distance_stream.sv
// ----------------------------------------------------------------------------
// bitap_hamming_distance_stream: streaming k-mismatch bitap matcher
// Each item passes the cell masks, check flags and group search before its
// result is registered. Throughput: one item per cycle unless the result
// stalls; all levels advance together and the check-bit search runs as three
// pipelined register stages. A stalled result holds the whole pipeline
// (text.ready drops). Reset clears all mask levels, the position counter and
// the masks; pattern_length resets to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bitap_hamming_distance_stream #(
    parameter int MAX_PATTERN = bhds_pkg::MAX_PATTERN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bhds_text_if.sink     text,
    bhds_result_if.source result,
    bhds_cfg_if.sink      cfg
);
    import bhds_pkg::*;

    localparam int NUM_LEVELS = MAX_PATTERN + 1;

    // ---------------- configuration registers ----------------
    logic [DIST_W-1:0] pattern_length_reg;
    logic [MASK_W-1:0] mask_a_reg, mask_c_reg, mask_g_reg, mask_t_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= DIST_W'(1);
            mask_a_reg <= '0;
            mask_c_reg <= '0;
            mask_g_reg <= '0;
            mask_t_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[DIST_W-1:0];
                REG_MASK_A:         mask_a_reg <= cfg.data;
                REG_MASK_C:         mask_c_reg <= cfg.data;
                REG_MASK_G:         mask_g_reg <= cfg.data;
                REG_MASK_T:         mask_t_reg <= cfg.data;
                default:            ;   // writes past the list are dropped
            endcase
        end
    end

    // effective pattern length, clamped to 1..MAX_PATTERN
    logic [DIST_W-1:0] m_eff;
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            m_eff = DIST_W'(1);
        end
        else if (pattern_length_reg > DIST_W'(MAX_PATTERN))
        begin
            m_eff = DIST_W'(MAX_PATTERN);
        end
        else
        begin
            m_eff = pattern_length_reg;
        end
    end

    // ---------------- pipeline control ----------------
    // Stages: cells hold the updated masks (v1), cell check flags (v2),
    // group search (v3), result register (vo). All move together.
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic advance, accept;

    assign advance    = !vo_reg || result.ready;
    assign text.ready = advance;
    assign accept     = text.valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // ---------------- text position and check bit ----------------
    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [POS_W-1:0] chk_reg, chk_next;
    logic [POS_W-1:0] m_minus1;

    assign m_minus1 = POS_W'(m_eff - DIST_W'(1));
    assign pos_cur  = text.text_start ? '0 : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        chk_next = chk_reg;
        if (accept)
        begin
            // saturate at the top; the check bit is limited to m-1
            pos_next = (pos_cur == '1) ? pos_cur : pos_cur + POS_W'(1);
            chk_next = (pos_cur < m_minus1) ? pos_cur : m_minus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next;
    end

    // ---------------- base mask select ----------------
    logic [MASK_W-1:0] base_mask;
    always_comb
    begin
        case (text.nucleotide)
            NUC_A:   base_mask = mask_a_reg;
            NUC_C:   base_mask = mask_c_reg;
            NUC_G:   base_mask = mask_g_reg;
            NUC_T:   base_mask = mask_t_reg;
            default: base_mask = '0;   // N and unused codes match nothing
        endcase
    end

    // ---------------- chain of mask cells ----------------
    cell_ctl_t         ctl;
    logic [MASK_W-1:0] level_mask [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] flags;

    assign ctl.upd     = accept;
    assign ctl.clr     = accept && text.text_start;
    assign ctl.chk_en  = advance;
    assign ctl.m       = m_eff;
    assign ctl.chk_idx = chk_reg;

    for (genvar d = 0; d < NUM_LEVELS; d++)
    begin : g_level
        logic [MASK_W-1:0] prev;
        if (d == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = level_mask[d-1];
        end

        bhds_cell #(
            .LEVEL (d)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .base      (base_mask),
            .prev_mask (prev),
            .mask      (level_mask[d]),
            .flag      (flags[d])
        );
    end

    // ---------------- least matching level ----------------
    bhds_min_level #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_min (
        .clk      (clk),
        .en_grp   (advance),
        .en_out   (advance),
        .flags    (flags),
        .m        (m_eff),
        .distance (result.distance)
    );

    assign result.valid = vo_reg;

    // ---------------- assertions ----------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !text.ready)
        else $error("text accepted while result stalled");

    a_start_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.text_start |=> pos_reg == POS_W'(1))
        else $error("position not restarted by text_start");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && advance |=> result.valid)
        else $error("finished item did not reach the result register");

endmodule
